// ----- rtl/core/tcps_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-class priority scheduler package
// Shared widths, codes, command and slot types, and pointer arithmetic.
// ----------------------------------------------------------------------------
package tcps_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = Q_AW + 1;
  localparam int TAG_W       = 47;
  localparam int MIN_W       = 11;
  localparam int LIM_W       = 5;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 16;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW     = CMDQ_AW + 1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SERVED   = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ARR_NRM = 2'd0,
    OP_ARR_URG = 2'd1,
    OP_SERVE   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INS_RD,
    BK_INS_CMP,
    BK_INS_WR,
    BK_SRV_RD,
    BK_SRV_OUT
  } bk_state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [MIN_W-1:0] minute;
  } slot_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [MIN_W-1:0] minute;
    logic [LIM_W-1:0] limit;
  } cmd_t;

  // Adds an offset below the depth to a ring pointer, wrapping at the depth.
  function automatic logic [Q_AW-1:0] wrap_add(input logic [Q_AW-1:0] base,
                                               input logic [FILL_W-1:0] off);
    logic [FILL_W-1:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= FILL_W'(QUEUE_DEPTH)) begin
      sum = sum - FILL_W'(QUEUE_DEPTH);
    end
    return sum[Q_AW-1:0];
  endfunction

endpackage

// ----- rtl/core/tcps_front.sv -----
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input items, classifies them and clamps the serve limit.
// ----------------------------------------------------------------------------
module tcps_front import tcps_pkg::*; (
  input  logic             start,
  input  logic             q_full,
  input  logic             in_kind,
  input  logic [TAG_W-1:0] in_entry_tag,
  input  logic [MIN_W-1:0] in_arrival_minute,
  input  logic             in_is_urgent,
  input  logic [LIM_W-1:0] in_serve_limit,
  output logic             busy,
  output logic             push,
  output cmd_t             push_cmd
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_cmd.tag    = in_entry_tag;
    push_cmd.minute = in_arrival_minute;
    push_cmd.limit  = (in_serve_limit > LIM_W'(MAX_RESULTS)) ?
                      LIM_W'(MAX_RESULTS) : in_serve_limit;
    if (in_kind) begin
      push_cmd.op = OP_SERVE;
    end else if (in_is_urgent) begin
      push_cmd.op = OP_ARR_URG;
    end else begin
      push_cmd.op = OP_ARR_NRM;
    end
  end

endmodule

// ----- rtl/core/tcps_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// Scheduler command queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module tcps_cmd_queue import tcps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, wp_nxt;
  logic [CMDQ_AW-1:0] rp_r, rp_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/tcps_back.sv -----
// ----------------------------------------------------------------------------
// Scheduler engine
// Holds the ordered urgent ring and the normal ring, inserts arrivals and
// serves entries, one result item at a time.
// ----------------------------------------------------------------------------
module tcps_back import tcps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [TAG_W-1:0] out_served_tag,
  output logic [MIN_W-1:0] out_served_minute,
  output logic             out_served_urgent,
  output logic             out_last,
  output logic [CNT_W-1:0] out_urgent_total,
  output logic [CNT_W-1:0] out_normal_total
);

  slot_t u_mem [QUEUE_DEPTH];
  slot_t n_mem [QUEUE_DEPTH];
  slot_t u_rdata_r;
  slot_t n_rdata_r;

  bk_state_t         state_r, state_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [FILL_W-1:0] pos_r, pos_nxt;
  logic [LIM_W-1:0]  cnt_r, cnt_nxt;
  logic              src_r, src_nxt;
  logic [Q_AW-1:0]   uhead_r, uhead_nxt;
  logic [FILL_W-1:0] ufill_r, ufill_nxt;
  logic [Q_AW-1:0]   nhead_r, nhead_nxt;
  logic [Q_AW-1:0]   ntail_r, ntail_nxt;
  logic [FILL_W-1:0] nfill_r, nfill_nxt;
  logic [CNT_W-1:0]  ucount_r, ucount_nxt;
  logic [CNT_W-1:0]  ncount_r, ncount_nxt;

  logic              u_we, n_we;
  logic [Q_AW-1:0]   u_waddr, u_raddr, n_waddr, n_raddr;
  slot_t             u_wdata, n_wdata;

  logic              emit;
  status_t           e_status;
  slot_t             e_slot;
  logic              e_urg, e_last;

  logic              out_valid_r;
  status_t           out_status_r;
  slot_t             out_slot_r;
  logic              out_urg_r, out_last_r;

  slot_t             new_slot;
  logic [FILL_W-1:0] ufill_pop, nfill_pop;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    src_nxt    = src_r;
    uhead_nxt  = uhead_r;
    ufill_nxt  = ufill_r;
    nhead_nxt  = nhead_r;
    ntail_nxt  = ntail_r;
    nfill_nxt  = nfill_r;
    ucount_nxt = ucount_r;
    ncount_nxt = ncount_r;
    new_slot   = '{tag: cur_r.tag, minute: cur_r.minute};
    u_we       = 1'b0;
    u_waddr    = uhead_r;
    u_wdata    = new_slot;
    u_raddr    = uhead_r;
    n_we       = 1'b0;
    n_waddr    = ntail_r;
    n_wdata    = '{tag: cmd.tag, minute: cmd.minute};
    n_raddr    = nhead_r;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    e_status   = ST_ACCEPTED;
    e_slot     = '0;
    e_urg      = 1'b0;
    e_last     = 1'b1;
    ufill_pop  = ufill_r;
    nfill_pop  = nfill_r;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          unique case (cmd.op)
            OP_ARR_NRM: begin
              emit = 1'b1;
              if (nfill_r == FILL_W'(QUEUE_DEPTH)) begin
                e_status = ST_DROPPED;
              end else begin
                n_we       = 1'b1;
                ntail_nxt  = wrap_add(ntail_r, FILL_W'(1));
                nfill_nxt  = nfill_r + 1'b1;
                ncount_nxt = (ncount_r == '1) ? ncount_r : ncount_r + 1'b1;
              end
            end
            OP_ARR_URG: begin
              if (ufill_r == FILL_W'(QUEUE_DEPTH)) begin
                emit     = 1'b1;
                e_status = ST_DROPPED;
              end else if (ufill_r == '0) begin
                emit       = 1'b1;
                u_we       = 1'b1;
                u_wdata    = '{tag: cmd.tag, minute: cmd.minute};
                ufill_nxt  = ufill_r + 1'b1;
                ucount_nxt = (ucount_r == '1) ? ucount_r : ucount_r + 1'b1;
              end else begin
                pos_nxt   = ufill_r;
                state_nxt = BK_INS_RD;
              end
            end
            OP_SERVE: begin
              if (cmd.limit == '0 || (ufill_r == '0 && nfill_r == '0)) begin
                emit     = 1'b1;
                e_status = ST_NONE;
              end else begin
                cnt_nxt   = cmd.limit;
                state_nxt = BK_SRV_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_INS_RD: begin
        u_raddr   = wrap_add(uhead_r, pos_r - 1'b1);
        state_nxt = BK_INS_CMP;
      end
      BK_INS_CMP: begin
        u_we    = 1'b1;
        u_waddr = wrap_add(uhead_r, pos_r);
        if (u_rdata_r.minute > cur_r.minute) begin
          u_wdata   = u_rdata_r;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = (pos_r == FILL_W'(1)) ? BK_INS_WR : BK_INS_RD;
        end else begin
          emit       = 1'b1;
          ufill_nxt  = ufill_r + 1'b1;
          ucount_nxt = (ucount_r == '1) ? ucount_r : ucount_r + 1'b1;
          state_nxt  = BK_IDLE;
        end
      end
      BK_INS_WR: begin
        u_we       = 1'b1;
        emit       = 1'b1;
        ufill_nxt  = ufill_r + 1'b1;
        ucount_nxt = (ucount_r == '1) ? ucount_r : ucount_r + 1'b1;
        state_nxt  = BK_IDLE;
      end
      BK_SRV_RD: begin
        src_nxt   = (ufill_r != '0);
        state_nxt = BK_SRV_OUT;
      end
      BK_SRV_OUT: begin
        emit     = 1'b1;
        e_status = ST_SERVED;
        e_urg    = src_r;
        if (src_r) begin
          e_slot    = u_rdata_r;
          ufill_pop = ufill_r - 1'b1;
          uhead_nxt = wrap_add(uhead_r, FILL_W'(1));
          ufill_nxt = ufill_pop;
        end else begin
          e_slot    = n_rdata_r;
          nfill_pop = nfill_r - 1'b1;
          nhead_nxt = wrap_add(nhead_r, FILL_W'(1));
          nfill_nxt = nfill_pop;
        end
        cnt_nxt   = cnt_r - 1'b1;
        e_last    = (cnt_r == LIM_W'(1)) || (ufill_pop == '0 && nfill_pop == '0);
        state_nxt = e_last ? BK_IDLE : BK_SRV_RD;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      uhead_r     <= '0;
      ufill_r     <= '0;
      nhead_r     <= '0;
      ntail_r     <= '0;
      nfill_r     <= '0;
      ucount_r    <= '0;
      ncount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      uhead_r     <= uhead_nxt;
      ufill_r     <= ufill_nxt;
      nhead_r     <= nhead_nxt;
      ntail_r     <= ntail_nxt;
      nfill_r     <= nfill_nxt;
      ucount_r    <= ucount_nxt;
      ncount_r    <= ncount_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    cnt_r <= cnt_nxt;
    src_r <= src_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_slot_r   <= e_slot;
      out_urg_r    <= e_urg;
      out_last_r   <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[u_waddr] <= u_wdata;
    end
    u_rdata_r <= u_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      n_mem[n_waddr] <= n_wdata;
    end
    n_rdata_r <= n_mem[n_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_served_tag    = out_slot_r.tag;
  assign out_served_minute = out_slot_r.minute;
  assign out_served_urgent = out_urg_r;
  assign out_last          = out_last_r;
  assign out_urgent_total  = ucount_r;
  assign out_normal_total  = ncount_r;

endmodule

// ----- rtl/core/two_class_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Two-class priority scheduler: each arrival gives one registered result; an
// urgent insert into a partly filled ring first walks it to keep it ordered.
// A serve gives its results one at a time. Results cannot be stalled. Reset
// empties both rings and clears the totals; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_class_priority_scheduler import tcps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_kind,
  input  logic [TAG_W-1:0] in_entry_tag,
  input  logic [MIN_W-1:0] in_arrival_minute,
  input  logic             in_is_urgent,
  input  logic [LIM_W-1:0] in_serve_limit,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [TAG_W-1:0] out_served_tag,
  output logic [MIN_W-1:0] out_served_minute,
  output logic             out_served_urgent,
  output logic             out_last,
  output logic [CNT_W-1:0] out_urgent_total,
  output logic [CNT_W-1:0] out_normal_total
);

  logic q_full, push, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  tcps_front u_front (
    .start             (start),
    .q_full            (q_full),
    .in_kind           (in_kind),
    .in_entry_tag      (in_entry_tag),
    .in_arrival_minute (in_arrival_minute),
    .in_is_urgent      (in_is_urgent),
    .in_serve_limit    (in_serve_limit),
    .busy              (busy),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  tcps_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (head_valid),
    .cmd               (head_cmd),
    .cmd_pop           (pop),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_served_tag    (out_served_tag),
    .out_served_minute (out_served_minute),
    .out_served_urgent (out_served_urgent),
    .out_last          (out_last),
    .out_urgent_total  (out_urgent_total),
    .out_normal_total  (out_normal_total)
  );

endmodule
